>>> rtl/core/crt_pkg.sv
// ---------------------------------------------------------------------------
// crt_pkg
// Shared constants for the coalescing reference-count table.
// ---------------------------------------------------------------------------
package crt_pkg;

  localparam int unsigned TableEntries   = 65536;
  localparam int unsigned GranuleShift   = 3;

  localparam int unsigned AddrW          = 48;
  localparam int unsigned CountW         = 8;
  localparam int unsigned HeapBytesW     = 20;
  localparam int unsigned CfgIdxW        = 1;

  localparam logic [CountW-1:0]     StuckCount     = 8'hFF;
  localparam logic [HeapBytesW-1:0] HeapBytesReset = 20'd524288;

  localparam logic [CfgIdxW-1:0] CfgHeapBase  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeapBytes = 1'b1;

endpackage

>>> rtl/core/coalescing_refcount_table.sv
// ---------------------------------------------------------------------------
// coalescing_refcount_table
// Sticky 8-bit reference counts per heap granule, updated per logged write.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one logged write: the new and
// the old referent address. Output channel (out_valid_o / out_stall_i) gives
// one result per input: both counts, the freed flag and the tracked flags.
// Configuration (cfg_valid_i / cfg_ready_o) sets heap_base (index 0) and
// heap_bytes (index 1); cfg_ready_o is always high. Write it only when idle.
// An item goes from its transfer to its result in the output register through
// the window arithmetic (S_LOC, S_IDX), a read of the dual-port count memory
// (S_RD) and a read-modify-write step (S_MOD). The next item is taken only
// once the previous one has left S_MOD for S_IDLE, so items never overlap in
// the count memory path.
// After reset the count memory is cleared one entry per cycle through port A,
// all TABLE_ENTRIES entries (65536 by default); in_stall_o stays high meanwhile.
// While out_stall_i holds a result, the next item is still taken and runs up
// to the write-back cycle, where it waits for the output register to free.
// ---------------------------------------------------------------------------
module coalescing_refcount_table #(
  parameter int unsigned TABLE_ENTRIES = crt_pkg::TableEntries,
  parameter int unsigned GRANULE_SHIFT = crt_pkg::GranuleShift
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [crt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [crt_pkg::AddrW-1:0]      cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [crt_pkg::AddrW-1:0]      in_new_ref_i,
  input  logic [crt_pkg::AddrW-1:0]      in_old_ref_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [crt_pkg::CountW-1:0]     out_new_count_o,
  output logic [crt_pkg::CountW-1:0]     out_old_count_o,
  output logic                           out_old_freed_o,
  output logic                           out_new_tracked_o,
  output logic                           out_old_tracked_o
);

  localparam int unsigned AW   = crt_pkg::AddrW;
  localparam int unsigned CW   = crt_pkg::CountW;
  localparam int unsigned BW   = crt_pkg::HeapBytesW;
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [AW:0]      LimBytes = (AW+1)'(TABLE_ENTRIES) << GRANULE_SHIFT;
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOC   = 6'b000100,
    S_IDX   = 6'b001000,
    S_RD    = 6'b010000,
    S_MOD   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]   heap_base_q;
  logic [BW-1:0]   heap_bytes_q;

  logic [AW-1:0]   new_ref_q, old_ref_q;
  logic [AW-1:0]   new_off_q, old_off_q;
  logic            new_ge_q, old_ge_q;
  logic            new_nz_q, old_nz_q;
  logic [AW:0]     end_q;
  logic            new_trk_q, old_trk_q;
  logic [IdxW-1:0] new_idx_q, old_idx_q;
  logic [IdxW-1:0] clr_q;
  logic [CW-1:0]   rd_a_q, rd_b_q;

  logic [CW-1:0]   mem [TABLE_ENTRIES];

  logic            in_fire, out_free, advance, same;
  logic [CW-1:0]   cn, co_in, co;
  logic            dec;
  logic            wa_en, wb_en;
  logic [IdxW-1:0] wa_addr;
  logic [CW-1:0]   wa_data;

  logic            out_valid_q;
  logic [CW-1:0]   out_new_count_q, out_old_count_q;
  logic            out_old_freed_q, out_new_tracked_q, out_old_tracked_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = (state_q == S_MOD) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_bytes_q <= crt_pkg::HeapBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        crt_pkg::CfgHeapBase:  heap_base_q  <= cfg_data_i;
        crt_pkg::CfgHeapBytes: heap_bytes_q <= cfg_data_i[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == LastIdx) state_d = S_IDLE;
      S_IDLE:  if (in_fire) state_d = S_LOC;
      S_LOC:   state_d = S_IDX;
      S_IDX:   state_d = S_RD;
      S_RD:    state_d = S_MOD;
      S_MOD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // window arithmetic, split over the S_LOC and S_IDX states
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_ref_q <= in_new_ref_i;
      old_ref_q <= in_old_ref_i;
    end
    if (state_q == S_LOC) begin
      new_off_q <= new_ref_q - heap_base_q;
      old_off_q <= old_ref_q - heap_base_q;
      new_ge_q  <= new_ref_q >= heap_base_q;
      old_ge_q  <= old_ref_q >= heap_base_q;
      new_nz_q  <= new_ref_q != '0;
      old_nz_q  <= old_ref_q != '0;
      end_q     <= {1'b0, heap_base_q} + {{(AW+1-BW){1'b0}}, heap_bytes_q};
    end
    if (state_q == S_IDX) begin
      new_trk_q <= new_nz_q && new_ge_q && ({1'b0, new_ref_q} < end_q)
                   && ({1'b0, new_off_q} < LimBytes);
      old_trk_q <= old_nz_q && old_ge_q && ({1'b0, old_ref_q} < end_q)
                   && ({1'b0, old_off_q} < LimBytes);
      new_idx_q <= new_off_q[GRANULE_SHIFT +: IdxW];
      old_idx_q <= old_off_q[GRANULE_SHIFT +: IdxW];
    end
  end

  // modify, with the increment forwarded to the decrement on a shared entry
  always_comb begin
    same  = new_trk_q && old_trk_q && (new_idx_q == old_idx_q);
    cn    = rd_a_q;
    if (new_trk_q && (rd_a_q != crt_pkg::StuckCount)) begin
      cn = rd_a_q + 1'b1;
    end
    co_in = same ? cn : rd_b_q;
    dec   = (co_in != '0) && (co_in != crt_pkg::StuckCount);
    co    = dec ? co_in - 1'b1 : co_in;
  end

  always_comb begin
    wa_en   = 1'b0;
    wa_addr = new_idx_q;
    wa_data = cn;
    if (state_q == S_CLEAR) begin
      wa_en   = 1'b1;
      wa_addr = clr_q;
      wa_data = '0;
    end else if (advance) begin
      wa_en   = new_trk_q && !same;
    end
    wb_en = advance && old_trk_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_a_q <= mem[new_idx_q];
      rd_b_q <= mem[old_idx_q];
    end
    if (wa_en) begin
      mem[wa_addr] <= wa_data;
    end
    if (wb_en) begin
      mem[old_idx_q] <= co;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_new_count_q   <= new_trk_q ? cn : '0;
      out_old_count_q   <= old_trk_q ? co : '0;
      out_old_freed_q   <= old_trk_q && dec && (co == '0);
      out_new_tracked_q <= new_trk_q;
      out_old_tracked_q <= old_trk_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_new_count_o   = out_new_count_q;
  assign out_old_count_o   = out_old_count_q;
  assign out_old_freed_o   = out_old_freed_q;
  assign out_new_tracked_o = out_new_tracked_q;
  assign out_old_tracked_o = out_old_tracked_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_LOC))
    else $error("accepted item did not start window arithmetic");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!out_valid_o && in_stall_o))
    else $error("activity during clearing pass");

  a_freed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_old_freed_o) |-> (out_old_tracked_o && (out_old_count_o == '0)))
    else $error("freed flag without a tracked zero count");

  a_untracked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_new_tracked_o) |-> (out_new_count_o == '0))
    else $error("untracked referent reports a count");

  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wa_en && wb_en) |-> (wa_addr != old_idx_q))
    else $error("both write ports hit one entry");

endmodule
